[rtl/mspd_pkg.sv]
// ----------------------------------------------------------------------------
// mspd_pkg - shared types and constants for the MAP sensor pressure decode
// Holds the command and result records, register indexes, sensor type codes,
// divider sizing and the table of fixed two-point sensor lines.
// ----------------------------------------------------------------------------
package mspd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TYPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_LOW_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_LOW_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_HIGH_MV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_HIGH_P   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_LOW_P  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_HIGH_P = 3'd6;

    // Sensor type codes
    localparam logic [3:0] TYPE_CUSTOM      = 4'd0;
    localparam logic [3:0] TYPE_FIXED_FIRST = 4'd1;
    localparam logic [3:0] TYPE_FIXED_LAST  = 4'd8;
    localparam logic [3:0] TYPE_FALLBACK    = 4'd9;

    // Field widths
    localparam int MV_W    = 13;
    localparam int PRESS_W = 21;

    localparam logic [MV_W-1:0]           FULL_SCALE_MV = 13'd5000;
    localparam logic signed [PRESS_W-1:0] PRESS_MAX     = 21'sd1000000;
    localparam logic signed [PRESS_W-1:0] PRESS_MIN     = -21'sd1000000;

    // Divider sizing: |dy| < 2^21, |dv| < 2^13, so |dy*dv| < 2^34
    localparam int NUM_W      = 34;
    localparam int DIV_STAGES = NUM_W;
    localparam int SUM_W      = NUM_W + 2;

    // Command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [MV_W-1:0]           x1;
        logic signed [PRESS_W-1:0] y1;
        logic [MV_W-1:0]           x2;
        logic signed [PRESS_W-1:0] y2;
    } t_line;

    typedef struct packed {
        logic signed [PRESS_W:0]   dy;
        logic signed [MV_W:0]      dv;
        logic signed [MV_W:0]      dx;
        logic signed [PRESS_W-1:0] y1;
        logic                      ok;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic signed [PRESS_W-1:0] pressure;
        logic                      valid_res;
    } t_res;

    function automatic t_line fixed_line(input logic [2:0] idx);
        t_line ln;
        case (idx)
            3'd0:    ln = '{13'd0,    -21'sd664, 13'd5000, 21'sd18278};
            3'd1:    ln = '{13'd0,    21'sd800,  13'd5000, 21'sd26000};
            3'd2:    ln = '{13'd250,  21'sd2000, 13'd4875, 21'sd25000};
            3'd3:    ln = '{13'd500,  21'sd9142, 13'd3000, 21'sd0};
            3'd4:    ln = '{13'd400,  21'sd1534, 13'd4500, 21'sd10000};
            3'd5:    ln = '{13'd0,    21'sd0,    13'd5000, 21'sd20000};
            3'd6:    ln = '{13'd631,  21'sd4000, 13'd4914, 21'sd30400};
            default: ln = '{13'd1700, 21'sd3332, 13'd3700, 21'sd10000};
        endcase
        return ln;
    endfunction

endpackage

[rtl/mspd_front.sv]
// ----------------------------------------------------------------------------
// mspd_front - configuration registers and sample classification
// Picks the line for the sensor type and forms the differences the back end
// needs: dy = y2-y1, dv = v-x1, dx = x2-x1, plus the result-good flag.
// ----------------------------------------------------------------------------
module mspd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mspd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mspd_pkg::MV_W-1:0]       i_sample_mv,
    output mspd_pkg::t_cmd                  o_cmd
);

    logic [3:0]                          r_sensor_type;
    logic [mspd_pkg::MV_W-1:0]           r_custom_low_mv;
    logic signed [mspd_pkg::PRESS_W-1:0] r_custom_low_p;
    logic [mspd_pkg::MV_W-1:0]           r_custom_high_mv;
    logic signed [mspd_pkg::PRESS_W-1:0] r_custom_high_p;
    logic signed [mspd_pkg::PRESS_W-1:0] r_fallback_low_p;
    logic signed [mspd_pkg::PRESS_W-1:0] r_fallback_high_p;

    mspd_pkg::t_line n_line;
    logic            n_known;
    logic [3:0]      n_type_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_type     <= mspd_pkg::TYPE_CUSTOM;
            r_custom_low_mv   <= '0;
            r_custom_low_p    <= '0;
            r_custom_high_mv  <= mspd_pkg::FULL_SCALE_MV;
            r_custom_high_p   <= 21'sd25000;
            r_fallback_low_p  <= '0;
            r_fallback_high_p <= 21'sd25000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mspd_pkg::CFG_SENSOR_TYPE:     r_sensor_type     <= i_cfg_data[3:0];
                mspd_pkg::CFG_CUSTOM_LOW_MV:   r_custom_low_mv   <= i_cfg_data[12:0];
                mspd_pkg::CFG_CUSTOM_LOW_P:    r_custom_low_p    <= i_cfg_data;
                mspd_pkg::CFG_CUSTOM_HIGH_MV:  r_custom_high_mv  <= i_cfg_data[12:0];
                mspd_pkg::CFG_CUSTOM_HIGH_P:   r_custom_high_p   <= i_cfg_data;
                mspd_pkg::CFG_FALLBACK_LOW_P:  r_fallback_low_p  <= i_cfg_data;
                mspd_pkg::CFG_FALLBACK_HIGH_P: r_fallback_high_p <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_type_m1 = r_sensor_type - 4'd1;
        n_known   = 1'b1;
        unique case (r_sensor_type) inside
            mspd_pkg::TYPE_CUSTOM: begin
                n_line = '{r_custom_low_mv, r_custom_low_p,
                           r_custom_high_mv, r_custom_high_p};
            end
            [mspd_pkg::TYPE_FIXED_FIRST:mspd_pkg::TYPE_FIXED_LAST]: begin
                n_line = mspd_pkg::fixed_line(n_type_m1[2:0]);
            end
            mspd_pkg::TYPE_FALLBACK: begin
                n_line = '{13'd0, r_fallback_low_p,
                           mspd_pkg::FULL_SCALE_MV, r_fallback_high_p};
            end
            default: begin
                n_line  = '0;
                n_known = 1'b0;
            end
        endcase

        o_cmd.dy = {n_line.y2[mspd_pkg::PRESS_W-1], n_line.y2}
                 - {n_line.y1[mspd_pkg::PRESS_W-1], n_line.y1};
        o_cmd.dv = {1'b0, i_sample_mv} - {1'b0, n_line.x1};
        o_cmd.dx = {1'b0, n_line.x2} - {1'b0, n_line.x1};
        o_cmd.y1 = n_line.y1;
        o_cmd.ok = n_known && (n_line.x1 != n_line.x2);
    end

endmodule

[rtl/mspd_queue.sv]
// ----------------------------------------------------------------------------
// mspd_queue - short command queue between front and back
// Four entries, head shown while not empty.
// ----------------------------------------------------------------------------
module mspd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mspd_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output mspd_pkg::t_cmd    o_cmd,
    output mspd_pkg::t_q_stat o_stat
);

    mspd_pkg::t_cmd              r_mem [mspd_pkg::Q_DEPTH];
    logic [mspd_pkg::Q_AW-1:0]   r_wr;
    logic [mspd_pkg::Q_AW-1:0]   r_rd;
    logic [mspd_pkg::Q_AW:0]     r_cnt;
    logic                        n_wr_en;
    logic                        n_rd_en;

    always_comb begin
        o_stat.full  = (r_cnt == (mspd_pkg::Q_AW+1)'(mspd_pkg::Q_DEPTH));
        o_stat.empty = (r_cnt == '0);
        n_wr_en      = i_push && !o_stat.full;
        n_rd_en      = i_pop && !o_stat.empty;
        o_cmd        = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (n_rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (n_wr_en && !n_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!n_wr_en && n_rd_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[rtl/mspd_back.sv]
// ----------------------------------------------------------------------------
// mspd_back - multiply, pipelined divide, offset and saturate
// One multiply stage, one restoring divider stage per quotient bit, a final
// add-and-clamp stage and a two-entry result buffer. The whole pipe holds
// when its last stage cannot drain.
// ----------------------------------------------------------------------------
module mspd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mspd_pkg::t_cmd i_cmd,
    input  logic           i_cmd_vld,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output mspd_pkg::t_res o_res
);

    localparam int N   = mspd_pkg::DIV_STAGES;
    localparam int FIN = N + 1;
    localparam int DW  = mspd_pkg::MV_W;
    localparam int YW  = mspd_pkg::PRESS_W;
    localparam int NW  = mspd_pkg::NUM_W;
    localparam int SW  = mspd_pkg::SUM_W;

    logic [FIN:0]              r_vld;
    logic [DW-1:0]             r_rem  [N+1];
    logic [NW-1:0]             r_dvd  [N+1];
    logic [DW-1:0]             r_d    [N+1];
    logic                      r_qneg [N+1];
    logic signed [YW-1:0]      r_y1   [N+1];
    logic                      r_ok   [N+1];
    mspd_pkg::t_res            r_fin;

    mspd_pkg::t_res            r_buf [2];
    logic                      r_bwr;
    logic                      r_brd;
    logic [1:0]                r_bcnt;

    logic                      adv;
    logic                      buf_full;
    logic                      buf_wr;
    logic                      buf_rd;

    logic [YW-1:0]             n_ady;
    logic [DW-1:0]             n_adv;
    logic [DW-1:0]             n_adx;
    logic [NW-1:0]             n_prod;
    logic [DW:0]               n_trial [N];
    logic [DW-1:0]             n_rem   [N];
    logic [NW-1:0]             n_dvd   [N];
    logic signed [SW-1:0]      n_q;
    logic signed [SW-1:0]      n_sum;
    mspd_pkg::t_res            n_fin;

    assign buf_full  = (r_bcnt == 2'd2);
    assign adv       = !r_vld[FIN] || !buf_full;
    assign buf_wr    = r_vld[FIN] && !buf_full;
    assign buf_rd    = i_pop && !o_empty;
    assign o_cmd_pop = adv && i_cmd_vld;
    assign o_empty   = (r_bcnt == 2'd0);
    assign o_res     = r_buf[r_brd];

    // magnitudes and product
    always_comb begin
        n_ady  = i_cmd.dy[YW] ? YW'(-i_cmd.dy) : YW'(i_cmd.dy);
        n_adv  = i_cmd.dv[DW] ? DW'(-i_cmd.dv) : DW'(i_cmd.dv);
        n_adx  = i_cmd.dx[DW] ? DW'(-i_cmd.dx) : DW'(i_cmd.dx);
        n_prod = {{(NW-YW){1'b0}}, n_ady} * {{(NW-DW){1'b0}}, n_adv};
    end

    // one quotient bit per stage
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_trial[k] = {r_rem[k], r_dvd[k][NW-1]};
            if (n_trial[k] >= {1'b0, r_d[k]}) begin
                n_rem[k] = DW'(n_trial[k] - {1'b0, r_d[k]});
                n_dvd[k] = {r_dvd[k][NW-2:0], 1'b1};
            end else begin
                n_rem[k] = n_trial[k][DW-1:0];
                n_dvd[k] = {r_dvd[k][NW-2:0], 1'b0};
            end
        end
    end

    // sign, offset and clamp
    always_comb begin
        n_q = {2'b00, r_dvd[N]};
        if (r_qneg[N]) begin
            n_q = -n_q;
        end
        n_sum = n_q + {{(SW-YW){r_y1[N][YW-1]}}, r_y1[N]};
        n_fin.valid_res = r_ok[N];
        if (!r_ok[N]) begin
            n_fin.pressure = '0;
        end else if (n_sum > SW'(mspd_pkg::PRESS_MAX)) begin
            n_fin.pressure = mspd_pkg::PRESS_MAX;
        end else if (n_sum < SW'(mspd_pkg::PRESS_MIN)) begin
            n_fin.pressure = mspd_pkg::PRESS_MIN;
        end else begin
            n_fin.pressure = n_sum[YW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[FIN-1:0], i_cmd_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0]  <= '0;
            r_dvd[0]  <= n_prod;
            r_d[0]    <= n_adx;
            r_qneg[0] <= i_cmd.dy[YW] ^ i_cmd.dv[DW] ^ i_cmd.dx[DW];
            r_y1[0]   <= i_cmd.y1;
            r_ok[0]   <= i_cmd.ok;
            for (int k = 0; k < N; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_dvd[k+1]  <= n_dvd[k];
                r_d[k+1]    <= r_d[k];
                r_qneg[k+1] <= r_qneg[k];
                r_y1[k+1]   <= r_y1[k];
                r_ok[k+1]   <= r_ok[k];
            end
            r_fin <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bwr  <= 1'b0;
            r_brd  <= 1'b0;
            r_bcnt <= '0;
        end else begin
            if (buf_wr) begin
                r_bwr <= ~r_bwr;
            end
            if (buf_rd) begin
                r_brd <= ~r_brd;
            end
            if (buf_wr && !buf_rd) begin
                r_bcnt <= r_bcnt + 2'd1;
            end else if (!buf_wr && buf_rd) begin
                r_bcnt <= r_bcnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_wr) begin
            r_buf[r_bwr] <= r_fin;
        end
    end

endmodule

[rtl/map_sensor_pressure_decode.sv]
// ----------------------------------------------------------------------------
// map_sensor_pressure_decode - manifold pressure sensor voltage to pressure
// Maps a millivolt sample onto a selectable two-point line, giving pressure
// in hundredths of kPa, truncated toward zero and clamped to +-1000000.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive i_sample_mv and push; a request is taken at a
//   clock edge where push is high and full is low.
//   Result queue side: while empty is low the oldest result sits on
//   o_pressure / o_valid_res; pop it by raising pop.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at
//   the edge; write only while no request is in flight.
//   Path: a request taken at a clock edge passes through the queue, the
//   multiply stage, 34 divider stages, the clamp stage and the result
//   buffer before it shows on the result ports.
//   Throughput: one request per cycle while the result buffer is not full,
//   set by the restoring divider, one quotient bit in each of its 34 stages.
//   Reset: clears both queues and the pipe valid bits and returns the
//   configuration registers to their reset values; no clearing pass.
//   Receiver stall: the back pipe holds once its result buffer is full and
//   its last stage holds a result; the front keeps taking requests until the
//   four-entry command queue fills, then raises full.
// ----------------------------------------------------------------------------
module map_sensor_pressure_decode (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mspd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic [mspd_pkg::MV_W-1:0]              i_sample_mv,
    input  logic                                   pop,
    output logic                                   empty,
    output logic signed [mspd_pkg::PRESS_W-1:0]    o_pressure,
    output logic                                   o_valid_res
);

    mspd_pkg::t_cmd    front_cmd;
    mspd_pkg::t_cmd    head_cmd;
    mspd_pkg::t_q_stat q_stat;
    logic              cmd_pop;
    mspd_pkg::t_res    res;

    // Classify the incoming sample against the selected line
    mspd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_mv (i_sample_mv),
        .o_cmd       (front_cmd)
    );

    // Decouple front and back so either side may stall on its own
    mspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    assign full = q_stat.full;

    // Multiply, divide, offset and clamp; buffer the results
    mspd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_cmd_vld (!q_stat.empty),
        .o_cmd_pop (cmd_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_pressure  = res.pressure;
    assign o_valid_res = res.valid_res;

endmodule

[rtl/mspd_checker.sv]
// ----------------------------------------------------------------------------
// mspd_checker - port-level checks for the pressure decode
// Watches reset behaviour, result holding, zero pressure on bad results and result value bounds.
// ----------------------------------------------------------------------------
module mspd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                pop,
    input logic                                empty,
    input logic signed [mspd_pkg::PRESS_W-1:0] o_pressure,
    input logic                                o_valid_res
);

    // Reset leaves both queues drained
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // A waiting result is held until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pressure) && $stable(o_valid_res)))
        else $error("waiting result changed before pop");

    // A bad result carries zero pressure
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_valid_res) |-> (o_pressure == '0))
        else $error("invalid result with non-zero pressure");

    // Good results stay inside the clamp limits
    a_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_pressure <= mspd_pkg::PRESS_MAX)
                 && (o_pressure >= mspd_pkg::PRESS_MIN)))
        else $error("pressure outside clamp limits");

endmodule

bind map_sensor_pressure_decode mspd_checker u_mspd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .o_pressure  (o_pressure),
    .o_valid_res (o_valid_res)
);

[test/mspd_pressure_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_pressure_checker - result checker for the MAP sensor pressure decode
// Tracks the configuration writes and predicts the pressure of every accepted
// sample. Compares each popped result, in order, with its prediction.
// ----------------------------------------------------------------------------
module mspd_pressure_checker
    import mspd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic [MV_W-1:0]           i_sample_mv,
    input  logic                      i_pop,
    input  logic                      i_empty,
    input  logic signed [PRESS_W-1:0] i_pressure,
    input  logic                      i_valid_res,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_flagged
);

    localparam longint                    LIMIT_P        = 1000000;
    localparam logic signed [PRESS_W-1:0] RESET_HIGH_P   = 21'sd25000;

    // Shadow copy of the configuration registers
    logic [3:0]                sensor_type;
    logic [MV_W-1:0]           cust_lo_mv;
    logic [MV_W-1:0]           cust_hi_mv;
    logic signed [PRESS_W-1:0] cust_lo_p;
    logic signed [PRESS_W-1:0] cust_hi_p;
    logic signed [PRESS_W-1:0] fb_lo_p;
    logic signed [PRESS_W-1:0] fb_hi_p;

    t_res pressure_q[$];
    int   fails   = 0;
    int   checked = 0;
    int   flagged = 0;

    function automatic t_res decode_pressure(input logic [MV_W-1:0] mv);
        t_res   r;
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint acc;
        logic   good;
        good = 1'b1;
        x1   = 0;
        y1   = 0;
        x2   = 0;
        y2   = 0;
        acc  = 0;
        if (sensor_type == TYPE_CUSTOM) begin
            x1 = cust_lo_mv;
            y1 = cust_lo_p;
            x2 = cust_hi_mv;
            y2 = cust_hi_p;
        end else if (sensor_type <= TYPE_FIXED_LAST) begin
            case (sensor_type - TYPE_FIXED_FIRST)
                4'd0:    begin x1 = 0;    y1 = -664; x2 = 5000; y2 = 18278; end
                4'd1:    begin x1 = 0;    y1 = 800;  x2 = 5000; y2 = 26000; end
                4'd2:    begin x1 = 250;  y1 = 2000; x2 = 4875; y2 = 25000; end
                4'd3:    begin x1 = 500;  y1 = 9142; x2 = 3000; y2 = 0;     end
                4'd4:    begin x1 = 400;  y1 = 1534; x2 = 4500; y2 = 10000; end
                4'd5:    begin x1 = 0;    y1 = 0;    x2 = 5000; y2 = 20000; end
                4'd6:    begin x1 = 631;  y1 = 4000; x2 = 4914; y2 = 30400; end
                default: begin x1 = 1700; y1 = 3332; x2 = 3700; y2 = 10000; end
            endcase
        end else if (sensor_type == TYPE_FALLBACK) begin
            x1 = 0;
            y1 = fb_lo_p;
            x2 = FULL_SCALE_MV;
            y2 = fb_hi_p;
        end else begin
            good = 1'b0;
        end
        if (good && x1 == x2)
            good = 1'b0;
        if (good) begin
            // integer division truncates toward zero
            acc = y1 + (y2 - y1) * (longint'(mv) - x1) / (x2 - x1);
            if (acc > LIMIT_P)
                acc = LIMIT_P;
            if (acc < -LIMIT_P)
                acc = -LIMIT_P;
        end
        r.pressure  = acc[PRESS_W-1:0];
        r.valid_res = good;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            sensor_type = TYPE_CUSTOM;
            cust_lo_mv  = '0;
            cust_lo_p   = '0;
            cust_hi_mv  = FULL_SCALE_MV;
            cust_hi_p   = RESET_HIGH_P;
            fb_lo_p     = '0;
            fb_hi_p     = RESET_HIGH_P;
            pressure_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                checked++;
                if (pressure_q.size() == 0) begin
                    $error("result with no sample waiting: pressure %0d valid_res %0b",
                           i_pressure, i_valid_res);
                    fails++;
                end else begin
                    want = pressure_q.pop_front();
                    if (!want.valid_res)
                        flagged++;
                    if (i_pressure !== want.pressure) begin
                        $error("pressure: expected %0d, got %0d", want.pressure, i_pressure);
                        fails++;
                    end
                    if (i_valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0b, got %0b",
                               want.valid_res, i_valid_res);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full)
                pressure_q.push_back(decode_pressure(i_sample_mv));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENSOR_TYPE:     sensor_type = i_cfg_data[3:0];
                    CFG_CUSTOM_LOW_MV:   cust_lo_mv  = i_cfg_data[MV_W-1:0];
                    CFG_CUSTOM_LOW_P:    cust_lo_p   = i_cfg_data;
                    CFG_CUSTOM_HIGH_MV:  cust_hi_mv  = i_cfg_data[MV_W-1:0];
                    CFG_CUSTOM_HIGH_P:   cust_hi_p   = i_cfg_data;
                    CFG_FALLBACK_LOW_P:  fb_lo_p     = i_cfg_data;
                    CFG_FALLBACK_HIGH_P: fb_hi_p     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pressure_q.size();
        o_checked    <= checked;
        o_flagged    <= flagged;
    end

endmodule

[test/map_sensor_pressure_decode_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_sensor_pressure_decode_tb - testbench for the MAP sensor pressure decode
// Runs a short directed pass over every sensor line, two unknown type codes,
// a degenerate custom line, raw out-of-range pressures and saturation, then
// random configurations with random samples under random push/pop idling.
// Checking is done by mspd_pressure_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module map_sensor_pressure_decode_tb;
    import mspd_pkg::*;

    localparam logic [3:0]            TYPE_LAST_CODE = 4'hF;
    localparam logic [MV_W-1:0]       MV_TOP         = '1;
    localparam logic [CFG_DATA_W-1:0] RAW_P_MIN      = 21'h100000;
    localparam logic [CFG_DATA_W-1:0] RAW_P_MAX      = 21'h0FFFFF;
    localparam int                    PHASES         = 10;
    localparam int                    PHASE_ITEMS    = 85;

    logic                      i_clk;
    logic                      i_rst_n   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_idx   = CFG_SENSOR_TYPE;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                      push      = 1'b0;
    logic                      full;
    logic [MV_W-1:0]           sample_mv = '0;
    logic                      pop       = 1'b0;
    logic                      empty;
    logic signed [PRESS_W-1:0] pressure;
    logic                      valid_res;

    int fail_count;
    int pending;
    int checked;
    int flagged;
    int sent   = 0;
    int writes = 0;
    bit calm   = 1'b0;     // set for the closing stretch: no idling on either side

    map_sensor_pressure_decode u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_sample_mv (sample_mv),
        .pop         (pop),
        .empty       (empty),
        .o_pressure  (pressure),
        .o_valid_res (valid_res)
    );

    mspd_pressure_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_sample_mv  (sample_mv),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_pressure   (pressure),
        .i_valid_res  (valid_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (~900 requests, each with
    // worst-case gaps, stalls and the full pipe, plus every drain).
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // Drive one register write at this edge; the caller drops the enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        writes++;
        @(posedge i_clk);
    endtask

    // Offer one sample, with an occasional idle burst in front of it, and
    // hold it until the block takes the request.
    task automatic send_sample(input logic [MV_W-1:0] mv);
        if (!calm && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        push      <= 1'b1;
        sample_mv <= mv;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    // Stop sending and wait until every predicted result has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [MV_W-1:0] pick_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return MV_TOP;
        if (k < 5)
            return MV_W'($urandom_range(0, FULL_SCALE_MV));
        return MV_W'($urandom_range(0, MV_TOP));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pressure();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return PRESS_MAX;
        if (k == 1)
            return PRESS_MIN;
        if (k == 2)
            return CFG_DATA_W'($urandom());     // any 21-bit pattern, in range or not
        return CFG_DATA_W'(int'($urandom_range(0, 2000000)) - 1000000);
    endfunction

    // Rewrite every register; the sensor type is weighted towards the lines
    // that actually compute something, with the odd unknown code thrown in.
    task automatic load_random_settings();
        int              r;
        logic [3:0]      kind;
        logic [MV_W-1:0] lo_mv;
        logic [MV_W-1:0] hi_mv;
        r = $urandom_range(0, 19);
        if (r < 6)
            kind = TYPE_CUSTOM;
        else if (r < 14)
            kind = TYPE_FIXED_FIRST + 4'(r - 6);
        else if (r < 17)
            kind = TYPE_FALLBACK;
        else
            kind = 4'($urandom_range(TYPE_FALLBACK + 1, TYPE_LAST_CODE));
        lo_mv = pick_sample();
        hi_mv = ($urandom_range(0, 7) == 0) ? lo_mv : pick_sample();
        write_reg(CFG_CUSTOM_LOW_MV, CFG_DATA_W'(lo_mv));
        write_reg(CFG_CUSTOM_LOW_P, pick_pressure());
        write_reg(CFG_CUSTOM_HIGH_MV, CFG_DATA_W'(hi_mv));
        write_reg(CFG_CUSTOM_HIGH_P, pick_pressure());
        write_reg(CFG_FALLBACK_LOW_P, pick_pressure());
        write_reg(CFG_FALLBACK_HIGH_P, pick_pressure());
        write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(kind));
        cfg_we <= 1'b0;
    endtask

    // Result side: pop in runs, with idle bursts between them unless calm.
    initial begin
        forever begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset line (custom, 0..5000 mV onto 0..25000): all-zero and
        // all-one samples, plus the upper point itself.
        send_sample('0);
        send_sample(MV_TOP);
        send_sample(FULL_SCALE_MV);

        // One sample on each fixed line
        for (int t = TYPE_FIXED_FIRST; t <= TYPE_FIXED_LAST; t++) begin
            wait_drained();
            write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(t));
            cfg_we <= 1'b0;
            send_sample(pick_sample());
        end

        // Fallback line pinned to the limits; past 5 V it must saturate
        wait_drained();
        write_reg(CFG_FALLBACK_LOW_P, PRESS_MIN);
        write_reg(CFG_FALLBACK_HIGH_P, PRESS_MAX);
        write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(TYPE_FALLBACK));
        cfg_we <= 1'b0;
        send_sample('0);
        send_sample(MV_W'(2500));
        send_sample(MV_TOP);

        // Unknown type codes: first and last of the unused range
        wait_drained();
        write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(TYPE_FALLBACK + 1));
        cfg_we <= 1'b0;
        send_sample(MV_W'(1));
        wait_drained();
        write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(TYPE_LAST_CODE));
        cfg_we <= 1'b0;
        send_sample(MV_W'(4095));

        // Degenerate custom line: both points at the same voltage
        wait_drained();
        write_reg(CFG_CUSTOM_LOW_MV, CFG_DATA_W'(4000));
        write_reg(CFG_CUSTOM_HIGH_MV, CFG_DATA_W'(4000));
        write_reg(CFG_SENSOR_TYPE, CFG_DATA_W'(TYPE_CUSTOM));
        cfg_we <= 1'b0;
        send_sample(MV_W'(4000));

        // Falling custom line with raw pressures beyond +-1000000: only the
        // final sum is clamped, so the ends must saturate.
        wait_drained();
        write_reg(CFG_CUSTOM_LOW_MV, CFG_DATA_W'(MV_TOP));
        write_reg(CFG_CUSTOM_HIGH_MV, '0);
        write_reg(CFG_CUSTOM_LOW_P, RAW_P_MIN);
        write_reg(CFG_CUSTOM_HIGH_P, RAW_P_MAX);
        cfg_we <= 1'b0;
        send_sample('0);
        send_sample(MV_W'(4096));
        send_sample(MV_TOP);

        // Random phases, each under a fresh configuration; the last is calm.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            calm = (ph == PHASES - 1);
            load_random_settings();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender once mid-phase until the pipe runs dry
                if (ph == PHASES / 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_sample(pick_sample());
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);   // past the full pipe, catch stragglers

        $display("Run covered %0d samples over %0d register writes: all sensor lines,",
                 sent, writes);
        $display("unknown codes, degenerate and saturating lines; %0d results checked (%0d invalid)",
                 checked, flagged);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
